>>> design/bed_pkg.sv
// Shared types, constants and helper functions for the backslash escape decoder.
package bed_pkg;

    typedef enum logic [2:0] {
        MODE_PLAIN = 3'd0,
        MODE_ESC   = 3'd1,
        MODE_OCT1  = 3'd2,
        MODE_OCT2  = 3'd3,
        MODE_HEX0  = 3'd4,
        MODE_HEX1  = 3'd5
    } mode_t;

    localparam logic [7:0] CH_BACKSLASH = 8'd92;
    localparam logic [7:0] CH_ZERO      = 8'd48;
    localparam logic [7:0] CH_SEVEN     = 8'd55;
    localparam logic [7:0] CH_UPPER_A   = 8'd65;
    localparam logic [7:0] CH_LOWER_A   = 8'd97;
    localparam logic [7:0] CH_LOWER_B   = 8'd98;
    localparam logic [7:0] CH_LOWER_E   = 8'd101;
    localparam logic [7:0] CH_LOWER_N   = 8'd110;
    localparam logic [7:0] CH_LOWER_R   = 8'd114;
    localparam logic [7:0] CH_LOWER_T   = 8'd116;
    localparam logic [7:0] CH_LOWER_X   = 8'd120;

    localparam logic [7:0] CODE_BEL = 8'd7;
    localparam logic [7:0] CODE_BS  = 8'd8;
    localparam logic [7:0] CODE_ESC = 8'd27;
    localparam logic [7:0] CODE_LF  = 8'd10;
    localparam logic [7:0] CODE_CR  = 8'd13;
    localparam logic [7:0] CODE_TAB = 8'd9;

    function automatic logic [3:0] hex_digit(input logic [7:0] b);
        logic [7:0] d;
        if (b >= CH_LOWER_A)
            d = b - CH_LOWER_A + 8'd10;
        else if (b >= CH_UPPER_A)
            d = b - CH_UPPER_A + 8'd10;
        else
            d = b - CH_ZERO;
        return d[3:0];
    endfunction

    function automatic logic [7:0] escape_letter(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CH_LOWER_A: r = CODE_BEL;
            CH_LOWER_B: r = CODE_BS;
            CH_LOWER_E: r = CODE_ESC;
            CH_LOWER_N: r = CODE_LF;
            CH_LOWER_R: r = CODE_CR;
            CH_LOWER_T: r = CODE_TAB;
            default:    r = b;
        endcase
        return r;
    endfunction

endpackage

>>> design/backslash_escape_decoder_unit.sv
// Streaming decoder of C-style backslash escapes, one byte per cycle unless the input stalls.
//
// The decoder accepts one escaped byte in every cycle while in_stall is low and
// delivers each decoded byte from its output register. A small mode register
// and a nine-bit pending value carry an escape or number across bytes, so bytes
// inside an escape produce no item unless they end the string. An output
// register backed by a one-entry skid buffer lets the input keep flowing while a
// result waits to be taken; the input stalls only while the skid buffer is
// occupied. Sustained rate is at most one item per cycle while out_stall is low.
module backslash_escape_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    bed_pkg::mode_t mode_reg;
    bed_pkg::mode_t mode_next;
    logic [8:0]     pend_reg;
    logic [8:0]     pend_next;

    logic           emit;
    logic [8:0]     val;
    logic           accept;
    logic [2:0]     oct_digit;
    logic [7:0]     oct_sub;

    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           out_last_reg;
    logic           skid_valid_reg;
    logic [7:0]     skid_byte_reg;
    logic           skid_last_reg;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign oct_sub   = in_byte - bed_pkg::CH_ZERO;
    assign oct_digit = oct_sub[2:0];

    always_comb
    begin
        emit      = 1'b0;
        val       = 9'd0;
        mode_next = mode_reg;
        pend_next = pend_reg;
        case (mode_reg)
            bed_pkg::MODE_ESC:
            begin
                if (in_byte >= bed_pkg::CH_ZERO && in_byte <= bed_pkg::CH_SEVEN)
                begin
                    pend_next = {6'd0, oct_digit};
                    mode_next = bed_pkg::MODE_OCT1;
                    emit      = in_last;
                    val       = {6'd0, oct_digit};
                end
                else if (in_byte == bed_pkg::CH_LOWER_X)
                begin
                    pend_next = 9'd0;
                    mode_next = bed_pkg::MODE_HEX0;
                    emit      = in_last;
                end
                else
                begin
                    val       = {1'b0, bed_pkg::escape_letter(in_byte)};
                    emit      = 1'b1;
                    mode_next = bed_pkg::MODE_PLAIN;
                end
            end
            bed_pkg::MODE_OCT1:
            begin
                pend_next = {pend_reg[5:0], oct_digit};
                mode_next = bed_pkg::MODE_OCT2;
                emit      = in_last;
                val       = {pend_reg[5:0], oct_digit};
            end
            bed_pkg::MODE_OCT2:
            begin
                pend_next = {pend_reg[5:0], oct_digit};
                val       = {pend_reg[5:0], oct_digit};
                emit      = 1'b1;
                mode_next = bed_pkg::MODE_PLAIN;
            end
            bed_pkg::MODE_HEX0:
            begin
                pend_next = {5'd0, bed_pkg::hex_digit(in_byte)};
                mode_next = bed_pkg::MODE_HEX1;
                emit      = in_last;
                val       = {5'd0, bed_pkg::hex_digit(in_byte)};
            end
            bed_pkg::MODE_HEX1:
            begin
                pend_next = {pend_reg[4:0], bed_pkg::hex_digit(in_byte)};
                val       = {pend_reg[4:0], bed_pkg::hex_digit(in_byte)};
                emit      = 1'b1;
                mode_next = bed_pkg::MODE_PLAIN;
            end
            default:
            begin
                if (in_byte == bed_pkg::CH_BACKSLASH)
                begin
                    mode_next = bed_pkg::MODE_ESC;
                    emit      = in_last;
                    val       = {1'b0, bed_pkg::CH_BACKSLASH};
                end
                else
                begin
                    val       = {1'b0, in_byte};
                    emit      = 1'b1;
                    mode_next = bed_pkg::MODE_PLAIN;
                end
            end
        endcase
        if (in_last)
        begin
            mode_next = bed_pkg::MODE_PLAIN;
            pend_next = 9'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= bed_pkg::MODE_PLAIN;
            pend_reg <= 9'd0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_stall)
        begin
            if (accept && emit)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_stall)
        begin
            if (accept && emit && !skid_valid_reg)
            begin
                skid_byte_reg <= val[7:0];
                skid_last_reg <= in_last;
            end
        end
        else if (skid_valid_reg)
        begin
            out_byte_reg <= skid_byte_reg;
            out_last_reg <= skid_last_reg;
        end
        else if (accept && emit)
        begin
            out_byte_reg <= val[7:0];
            out_last_reg <= in_last;
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid buffer holds an item while the output register is empty.");

    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> mode_reg == bed_pkg::MODE_PLAIN && pend_reg == 9'd0)
        else $error("Decode state not cleared after the final byte of a string.");

    a_number_completes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode_reg == bed_pkg::MODE_OCT2 || mode_reg == bed_pkg::MODE_HEX1)
        |=> out_valid_reg)
        else $error("Completed number did not produce an item.");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_stall |=> !skid_valid_reg)
        else $error("Skid buffer did not drain when the output was taken.");

endmodule

>>> sim/backslash_escape_decoder_unit_tb.sv
// Self-checking testbench for the backslash escape decoder, directed rows then random strings.
`timescale 1ns / 1ps

module backslash_escape_decoder_unit_tb;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int QUIET_LIMIT    = 2000;
    localparam int CALM_FIRST     = 700;
    localparam int CALM_END       = 1000;
    localparam int IDLE_PERCENT   = 37;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic       drain;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic       t_emit;
        logic [7:0] t_data;
        logic       t_last;
    } stim_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } decoded_t;

    localparam stim_t DIRECTED_ROWS [29] = '{
        '{1'b0, 8'h00,                 1'b0, 1'b1, 1'b1, 8'h00,                 1'b0},
        '{1'b0, 8'hFF,                 1'b1, 1'b1, 1'b1, 8'hFF,                 1'b1},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_A,   1'b0, 1'b1, 1'b1, bed_pkg::CODE_BEL,     1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_B,   1'b0, 1'b1, 1'b1, bed_pkg::CODE_BS,      1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_E,   1'b0, 1'b1, 1'b1, bed_pkg::CODE_ESC,     1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_N,   1'b0, 1'b1, 1'b1, bed_pkg::CODE_LF,      1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_R,   1'b0, 1'b1, 1'b1, bed_pkg::CODE_CR,      1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_T,   1'b1, 1'b1, 1'b1, bed_pkg::CODE_TAB,     1'b1},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_SEVEN,     1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_SEVEN,     1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_SEVEN,     1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_X,   1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_A,   1'b0, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, 8'h46,                 1'b1, 1'b0, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b1, 1'b1, 1'b1, bed_pkg::CH_BACKSLASH, 1'b1},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_LOWER_X,   1'b1, 1'b1, 1'b1, 8'h00,                 1'b1},
        '{1'b0, bed_pkg::CH_BACKSLASH, 1'b0, 1'b1, 1'b0, 8'h00,                 1'b0},
        '{1'b0, bed_pkg::CH_SEVEN,     1'b1, 1'b1, 1'b1, 8'h07,                 1'b1}
    };

    localparam logic [7:0] ESC_LETTERS [6] = '{
        bed_pkg::CH_LOWER_A, bed_pkg::CH_LOWER_B, bed_pkg::CH_LOWER_E,
        bed_pkg::CH_LOWER_N, bed_pkg::CH_LOWER_R, bed_pkg::CH_LOWER_T
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       in_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       out_last;

    bed_pkg::mode_t dec_mode = bed_pkg::MODE_PLAIN;
    logic [8:0]     acc_value = 9'd0;
    decoded_t       expected_out [$];
    stim_t          random_items [$];
    bit             calm = 1'b0;
    int             mismatches = 0;
    int             quiet_cycles = 0;

    backslash_escape_decoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    always #1 clk = ~clk;

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        if (c >= bed_pkg::CH_LOWER_A)
            d = c - 8'd87;
        else if (c >= bed_pkg::CH_UPPER_A)
            d = c - 8'd55;
        else
            d = c - bed_pkg::CH_ZERO;
        return d[3:0];
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic last,
                               output logic emit, output logic [7:0] value);
        emit = 1'b0;
        value = 8'h00;
        case (dec_mode)
            bed_pkg::MODE_ESC:
            begin
                if (b >= bed_pkg::CH_ZERO && b <= bed_pkg::CH_SEVEN)
                begin
                    acc_value = {6'd0, b[2:0]};
                    dec_mode = bed_pkg::MODE_OCT1;
                    emit = last;
                    value = acc_value[7:0];
                end
                else if (b == bed_pkg::CH_LOWER_X)
                begin
                    acc_value = 9'd0;
                    dec_mode = bed_pkg::MODE_HEX0;
                    emit = last;
                end
                else
                begin
                    emit = 1'b1;
                    dec_mode = bed_pkg::MODE_PLAIN;
                    case (b)
                        bed_pkg::CH_LOWER_A: value = bed_pkg::CODE_BEL;
                        bed_pkg::CH_LOWER_B: value = bed_pkg::CODE_BS;
                        bed_pkg::CH_LOWER_E: value = bed_pkg::CODE_ESC;
                        bed_pkg::CH_LOWER_N: value = bed_pkg::CODE_LF;
                        bed_pkg::CH_LOWER_R: value = bed_pkg::CODE_CR;
                        bed_pkg::CH_LOWER_T: value = bed_pkg::CODE_TAB;
                        default:             value = b;
                    endcase
                end
            end
            bed_pkg::MODE_OCT1:
            begin
                acc_value = {acc_value[5:0], b[2:0]};
                dec_mode = bed_pkg::MODE_OCT2;
                emit = last;
                value = acc_value[7:0];
            end
            bed_pkg::MODE_OCT2:
            begin
                acc_value = {acc_value[5:0], b[2:0]};
                dec_mode = bed_pkg::MODE_PLAIN;
                emit = 1'b1;
                value = acc_value[7:0];
            end
            bed_pkg::MODE_HEX0:
            begin
                acc_value = {5'd0, hex_value(b)};
                dec_mode = bed_pkg::MODE_HEX1;
                emit = last;
                value = acc_value[7:0];
            end
            bed_pkg::MODE_HEX1:
            begin
                acc_value = {acc_value[4:0], hex_value(b)};
                dec_mode = bed_pkg::MODE_PLAIN;
                emit = 1'b1;
                value = acc_value[7:0];
            end
            default:
            begin
                if (b == bed_pkg::CH_BACKSLASH)
                begin
                    dec_mode = bed_pkg::MODE_ESC;
                    emit = last;
                    value = bed_pkg::CH_BACKSLASH;
                end
                else
                begin
                    dec_mode = bed_pkg::MODE_PLAIN;
                    emit = 1'b1;
                    value = b;
                end
            end
        endcase
        if (last)
        begin
            dec_mode = bed_pkg::MODE_PLAIN;
            acc_value = 9'd0;
        end
    endtask

    task automatic flag_mismatch(input string msg);
        if (mismatches < REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_item(input stim_t s);
        logic       emit;
        logic [7:0] value;
        decoded_t   want;
        if (s.drain)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (expected_out.size() != 0);
        end
        while (!calm && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= s.data;
        in_last <= s.last;
        do
            @(posedge clk);
        while (in_stall);
        decode_byte(s.data, s.last, emit, value);
        want.data = value;
        want.last = s.last;
        if (s.typed)
        begin
            emit = s.t_emit;
            want.data = s.t_data;
            want.last = s.t_last;
        end
        if (emit)
            expected_out.push_back(want);
    endtask

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_out.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected item byte=%0d last=%0d",
                                        out_byte, out_last));
            end
            else
            begin
                want = expected_out.pop_front();
                if (out_byte !== want.data || out_last !== want.last)
                    flag_mismatch($sformatf("expected byte=%0d last=%0d, got byte=%0d last=%0d",
                                            want.data, want.last, out_byte, out_last));
            end
        end
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [7:0] text [$];
        logic [7:0] c;
        stim_t      s;
        int         i;
        int         j;
        int         n;
        int         kind;
        int         tok_start;
        int         keep;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(DIRECTED_ROWS); i++)
            send_item(DIRECTED_ROWS[i]);

        // Random strings mix plain bytes with escapes whose content is random;
        // some end in the middle of an escape and a few bytes are pure noise.
        while (random_items.size() < RANDOM_ITEMS)
        begin
            text.delete();
            tok_start = 0;
            n = $urandom_range(1, 10);
            for (j = 0; j < n; j++)
            begin
                tok_start = text.size();
                kind = $urandom_range(99);
                if (kind < 35)
                begin
                    do
                        c = 8'($urandom_range(255));
                    while (c == bed_pkg::CH_BACKSLASH);
                    text.push_back(c);
                end
                else if (kind < 55)
                begin
                    text.push_back(bed_pkg::CH_BACKSLASH);
                    text.push_back(ESC_LETTERS[$urandom_range(5)]);
                end
                else if (kind < 65)
                begin
                    text.push_back(bed_pkg::CH_BACKSLASH);
                    text.push_back(8'($urandom_range(255)));
                end
                else if (kind < 80)
                begin
                    text.push_back(bed_pkg::CH_BACKSLASH);
                    text.push_back(bed_pkg::CH_ZERO + 8'($urandom_range(7)));
                    repeat (2)
                    begin
                        if ($urandom_range(4) == 0)
                            text.push_back(8'($urandom_range(255)));
                        else
                            text.push_back(bed_pkg::CH_ZERO + 8'($urandom_range(7)));
                    end
                end
                else if (kind < 95)
                begin
                    text.push_back(bed_pkg::CH_BACKSLASH);
                    text.push_back(bed_pkg::CH_LOWER_X);
                    repeat (2)
                    begin
                        keep = $urandom_range(15);
                        if ($urandom_range(4) == 0)
                            c = 8'($urandom_range(255));
                        else if (keep < 10)
                            c = bed_pkg::CH_ZERO + 8'(keep);
                        else if ($urandom_range(1) == 0)
                            c = bed_pkg::CH_LOWER_A + 8'(keep - 10);
                        else
                            c = bed_pkg::CH_UPPER_A + 8'(keep - 10);
                        text.push_back(c);
                    end
                end
                else
                begin
                    text.push_back(8'($urandom_range(255)));
                end
            end
            if ($urandom_range(4) == 0)
            begin
                keep = $urandom_range(tok_start + 1, text.size());
                while (text.size() > keep)
                    void'(text.pop_back());
            end
            for (j = 0; j < text.size(); j++)
            begin
                s = '0;
                s.data = text[j];
                s.last = (j == text.size() - 1);
                s.drain = (j == 0) && (random_items.size() == 0 || $urandom_range(49) == 0);
                random_items.push_back(s);
            end
        end

        for (i = 0; i < random_items.size(); i++)
        begin
            calm = (i >= CALM_FIRST && i < CALM_END);
            send_item(random_items[i]);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (expected_out.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
